/* src/kti_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package kti_pkg;
   localparam int CHANNELS       = 13;
   localparam int CH_HEADING     = 6;
   localparam int CH_EXT_FIRST   = 10;
   localparam int DEF_MAX_FRAMES = 4096;

   localparam logic [1:0] MODE_STAGE  = 2'd0;
   localparam logic [1:0] MODE_COMMIT = 2'd1;
   localparam logic [1:0] MODE_QUERY  = 2'd2;
   localparam logic [1:0] MODE_CLEAR  = 2'd3;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_INVALID = 3'd1;
   localparam logic [2:0] ST_ORDER   = 3'd2;
   localparam logic [2:0] ST_FULL    = 3'd3;
   localparam logic [2:0] ST_EMPTY   = 3'd4;

   localparam logic [3:0] CH_LAST = 4'(CHANNELS - 1);

   // degrees in Q24.24
   localparam logic [47:0] SIGN48 = 48'h8000_0000_0000;
   localparam logic [48:0] DEG360 = 49'h0_0001_6800_0000;
   localparam logic [48:0] DEG720 = 49'h0_0002_D000_0000;
   localparam logic signed [49:0] DEG180 = 50'sh0_0000_B400_0000;

   typedef struct packed {
      logic [1:0]         mode;
      logic [3:0]         channel;
      logic signed [47:0] value;
      logic [63:0]        time_ns;
      logic [63:0]        sequence_req;
      logic [63:0]        elapsed_ns;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [3:0]         out_channel;
      logic signed [47:0] out_value;
      logic [63:0]        out_sequence;
      logic [63:0]        out_time_ns;
      logic               last;
   } rsp_type;
endpackage
`default_nettype wire

/* src/keyframe_track_interpolator.sv */
`timescale 1ns / 1ps
`default_nettype none
// Stage/commit/clear: one response per request; requests are taken only while idle.
// Query: a binary search of the frame times, then a 16-step division where needed,
// then one response per channel (two channel-memory reads, multiply, round).
// Each memory has a single read port; the divider is a 16-step restoring divider.
// Reset (synchronous, high) empties the track and zeroes the staged frame;
// frame memory contents are not cleared and need no clearing pass.
module keyframe_track_interpolator #(
   parameter int MAX_FRAMES = kti_pkg::DEF_MAX_FRAMES
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_stall,
   input  kti_pkg::req_type req_data,
   output logic             rsp_valid,
   input  wire              rsp_stall,
   output kti_pkg::rsp_type rsp_data
);
   import kti_pkg::*;

   localparam int FIDX = $clog2(MAX_FRAMES);
   localparam int CNTW = $clog2(MAX_FRAMES + 1);
   localparam int CIDX = $clog2(MAX_FRAMES * CHANNELS);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_DEC     = 4'd1;
   localparam logic [3:0] S_ONE     = 4'd2;
   localparam logic [3:0] S_CMT_CHK = 4'd3;
   localparam logic [3:0] S_CMT_WR  = 4'd4;
   localparam logic [3:0] S_T0      = 4'd5;
   localparam logic [3:0] S_BS      = 4'd6;
   localparam logic [3:0] S_BS_CMP  = 4'd7;
   localparam logic [3:0] S_UP      = 4'd8;
   localparam logic [3:0] S_LW      = 4'd9;
   localparam logic [3:0] S_DIV     = 4'd10;
   localparam logic [3:0] S_CH_A    = 4'd11;
   localparam logic [3:0] S_CH_B    = 4'd12;
   localparam logic [3:0] S_CH_M    = 4'd13;
   localparam logic [3:0] S_CH_R    = 4'd14;

   // frame memory holds {sequence, time}; channel memory holds 13 words per frame
   logic [127:0] fmem [MAX_FRAMES];
   logic [47:0]  cmem [MAX_FRAMES * CHANNELS];
   logic [127:0] fmem_rd_ff;
   logic [47:0]  cmem_rd_ff;
   logic [FIDX-1:0] fmem_raddr;
   logic [CIDX-1:0] cmem_raddr;
   logic            fmem_we, cmem_we;

   logic [3:0]      state_ff;
   req_type         req_ff;
   logic [CNTW-1:0] count_ff;
   logic [47:0]     staged_ff [CHANNELS];
   logic [2:0]      status_ff;
   logic [CNTW-1:0] lo_ff, hi_ff;
   logic [FIDX-1:0] mid_ff, up_ff;
   logic [CIDX-1:0] cbase_ff, up_base_ff, lw_base_ff;
   logic [63:0]     target_ff, tb_ff, den_ff, rem_ff, seq_a_ff, seq_b_ff;
   logic [15:0]     q_ff, al_ff;
   logic [3:0]      ch_ff, divcnt_ff;
   logic [47:0]     a_ff;
   logic [63:0]     p0_ff, p1_ff, dp_ff;
   logic            rsp_valid_ff;
   rsp_type         rsp_data_ff;

   logic [63:0] rtime, rseq;
   logic [64:0] sum65;
   logic [63:0] target_in, num_in, den_in;
   logic [FIDX-1:0] mid_in, up_in, lw_in;
   logic        order_bad, frame_ok, resp_free, rsp_emit;
   logic [64:0] div_sh;
   logic        div_take;
   logic [63:0] rem_in;
   logic [15:0] q_in;
   logic [47:0] ua, ub;
   logic [16:0] wa;
   logic [64:0] p0_full, p1_full;
   logic [63:0] p0_in, p1_in, dp_in;
   logic signed [49:0] hd_raw, hd;
   logic signed [66:0] dp_full;
   logic [63:0] s_sum, hs;
   logic [48:0] lin_v, hv, hv_mod;
   logic [47:0] val_in;
   logic [63:0] seq_in;

   assign rtime     = fmem_rd_ff[63:0];
   assign rseq      = fmem_rd_ff[127:64];
   assign resp_free = !rsp_valid_ff || !rsp_stall;
   // a response register load happens only in the two emitting states
   assign rsp_emit  = ((state_ff == S_ONE) || (state_ff == S_CH_R)) && resp_free;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      // target = first time + elapsed, saturating
      sum65     = {1'b0, rtime} + {1'b0, req_ff.elapsed_ns};
      target_in = sum65[64] ? '1 : sum65[63:0];
      mid_in    = FIDX'(lo_ff + ((hi_ff - lo_ff) >> 1));
      up_in     = (lo_ff >= count_ff) ? FIDX'(count_ff - 1'b1) : FIDX'(lo_ff);
      lw_in     = (rtime > target_ff && up_ff != '0) ? up_ff - 1'b1 : up_ff;
      num_in    = (target_ff > rtime) ? target_ff - rtime : '0;
      den_in    = tb_ff - rtime;

      order_bad = (count_ff != '0) &&
                  (req_ff.sequence_req <= rseq || req_ff.time_ns <= rtime);
      frame_ok  = !staged_ff[CH_HEADING][47] &&
                  ({1'b0, staged_ff[CH_HEADING]} < DEG360);
      for (int c = CH_EXT_FIRST; c < CHANNELS; c++) begin
         if (staged_ff[c][47] || staged_ff[c] == '0) frame_ok = 1'b0;
      end

      // restoring divider step
      div_sh   = {rem_ff, 1'b0};
      div_take = div_sh[64] || (div_sh[63:0] >= den_ff);
      rem_in   = div_take ? div_sh[63:0] - den_ff : div_sh[63:0];
      q_in     = {q_ff[14:0], div_take};

      // lerp products (offset binary for the linear channels)
      ua      = a_ff ^ SIGN48;
      ub      = cmem_rd_ff ^ SIGN48;
      wa      = 17'h1_0000 - {1'b0, al_ff};
      p0_full = ua * wa;
      p1_full = ub * al_ff;
      p0_in   = p0_full[63:0];
      p1_in   = p1_full[63:0];
      // heading: shortest way round
      hd_raw = $signed({2'b00, cmem_rd_ff}) - $signed({2'b00, a_ff});
      if (hd_raw > DEG180) hd = hd_raw - $signed({1'b0, DEG360});
      else if (hd_raw < -DEG180) hd = hd_raw + $signed({1'b0, DEG360});
      else hd = hd_raw;
      dp_full = hd * $signed({1'b0, al_ff});
      dp_in   = dp_full[63:0];

      s_sum = p0_ff + p1_ff;
      lin_v = {1'b0, s_sum[63:16]} + 49'(s_sum[15]);
      hs    = ((64'(a_ff) + 64'(DEG360)) << 16) + dp_ff;
      hv    = {1'b0, hs[63:16]} + 49'(hs[15]);
      if (hv >= DEG720) hv_mod = hv - DEG720;
      else if (hv >= DEG360) hv_mod = hv - DEG360;
      else hv_mod = hv;
      val_in = (ch_ff == 4'(CH_HEADING)) ? hv_mod[47:0] : (lin_v[47:0] ^ SIGN48);
      seq_in = (al_ff < 16'h8000) ? seq_a_ff : seq_b_ff;
   end

   // read addresses come straight from the sequencer so data lands next cycle
   always_comb begin
      fmem_raddr = '0;
      cmem_raddr = lw_base_ff + CIDX'(ch_ff);
      unique case (state_ff)
         S_DEC:  fmem_raddr = (req_ff.mode == MODE_COMMIT) ?
                              FIDX'(count_ff - 1'b1) : '0;
         S_BS:   fmem_raddr = (lo_ff < hi_ff) ? mid_in : up_in;
         S_UP:   fmem_raddr = lw_in;
         S_CH_B: cmem_raddr = up_base_ff + CIDX'(ch_ff);
         default: ;
      endcase
   end

   assign fmem_we = (state_ff == S_CMT_CHK) && !order_bad && frame_ok;
   assign cmem_we = (state_ff == S_CMT_WR);

   always_ff @(posedge clock) begin
      if (fmem_we) fmem[FIDX'(count_ff)] <= {req_ff.sequence_req, req_ff.time_ns};
      fmem_rd_ff <= fmem[fmem_raddr];
      if (cmem_we) cmem[cbase_ff + CIDX'(ch_ff)] <= staged_ff[ch_ff];
      cmem_rd_ff <= cmem[cmem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < CHANNELS; c++) staged_ff[c] <= '0;
      end else begin
         if (rsp_emit) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  req_ff   <= req_data;
                  state_ff <= S_DEC;
               end
            end
            S_DEC: begin
               state_ff <= S_ONE;
               unique case (req_ff.mode)
                  MODE_STAGE: begin
                     if (req_ff.channel >= 4'(CHANNELS)) status_ff <= ST_INVALID;
                     else begin
                        staged_ff[req_ff.channel] <= req_ff.value;
                        status_ff <= ST_OK;
                     end
                  end
                  MODE_COMMIT: begin
                     if (req_ff.sequence_req == '0) status_ff <= ST_INVALID;
                     else if (count_ff >= CNTW'(MAX_FRAMES)) status_ff <= ST_FULL;
                     else begin
                        cbase_ff <= CIDX'(count_ff * CHANNELS);
                        state_ff <= S_CMT_CHK;
                     end
                  end
                  MODE_QUERY: begin
                     if (count_ff == '0) status_ff <= ST_EMPTY;
                     else state_ff <= S_T0;
                  end
                  MODE_CLEAR: begin
                     count_ff  <= '0;
                     status_ff <= ST_OK;
                  end
                  default: ;
               endcase
            end
            S_ONE: begin
               if (resp_free) begin
                  rsp_data_ff  <= '{status: status_ff, out_channel: '0, out_value: '0,
                                    out_sequence: '0, out_time_ns: '0, last: 1'b1};
                  state_ff     <= S_IDLE;
               end
            end
            S_CMT_CHK: begin
               ch_ff <= '0;
               if (order_bad) begin
                  status_ff <= ST_ORDER;
                  state_ff  <= S_ONE;
               end else if (!frame_ok) begin
                  status_ff <= ST_INVALID;
                  state_ff  <= S_ONE;
               end else state_ff <= S_CMT_WR;
            end
            S_CMT_WR: begin
               ch_ff <= ch_ff + 1'b1;
               if (ch_ff == CH_LAST) begin
                  count_ff  <= count_ff + 1'b1;
                  status_ff <= ST_OK;
                  state_ff  <= S_ONE;
               end
            end
            S_T0: begin
               target_ff <= target_in;
               lo_ff     <= '0;
               hi_ff     <= count_ff;
               state_ff  <= S_BS;
            end
            S_BS: begin
               if (lo_ff < hi_ff) begin
                  mid_ff   <= mid_in;
                  state_ff <= S_BS_CMP;
               end else begin
                  up_ff      <= up_in;
                  up_base_ff <= CIDX'(up_in * CHANNELS);
                  state_ff   <= S_UP;
               end
            end
            S_BS_CMP: begin
               if (rtime < target_ff) lo_ff <= CNTW'(mid_ff) + 1'b1;
               else hi_ff <= CNTW'(mid_ff);
               state_ff <= S_BS;
            end
            S_UP: begin
               tb_ff      <= rtime;
               seq_b_ff   <= rseq;
               lw_base_ff <= CIDX'(lw_in * CHANNELS);
               state_ff   <= S_LW;
            end
            S_LW: begin
               seq_a_ff  <= rseq;
               den_ff    <= den_in;
               rem_ff    <= num_in;
               q_ff      <= '0;
               divcnt_ff <= '0;
               ch_ff     <= '0;
               if (tb_ff > rtime) begin
                  if (num_in >= den_in) begin
                     al_ff    <= 16'hFFFF;
                     state_ff <= S_CH_A;
                  end else state_ff <= S_DIV;
               end else begin
                  al_ff    <= '0;
                  state_ff <= S_CH_A;
               end
            end
            S_DIV: begin
               rem_ff    <= rem_in;
               q_ff      <= q_in;
               divcnt_ff <= divcnt_ff + 1'b1;
               if (divcnt_ff == 4'd15) begin
                  al_ff    <= q_in;
                  state_ff <= S_CH_A;
               end
            end
            S_CH_A: state_ff <= S_CH_B;
            S_CH_B: begin
               a_ff     <= cmem_rd_ff;
               state_ff <= S_CH_M;
            end
            S_CH_M: begin
               p0_ff    <= p0_in;
               p1_ff    <= p1_in;
               dp_ff    <= dp_in;
               state_ff <= S_CH_R;
            end
            S_CH_R: begin
               if (resp_free) begin
                  rsp_data_ff  <= '{status: ST_OK, out_channel: ch_ff,
                                    out_value: val_in, out_sequence: seq_in,
                                    out_time_ns: target_ff,
                                    last: (ch_ff == CH_LAST)};
                  ch_ff        <= ch_ff + 1'b1;
                  state_ff     <= (ch_ff == CH_LAST) ? S_IDLE : S_CH_A;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

/* src/kti_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module kti_checker (
   input wire              clock,
   input wire              reset,
   input wire              req_valid,
   input wire              req_stall,
   input kti_pkg::req_type req_data,
   input wire              rsp_valid,
   input wire              rsp_stall,
   input kti_pkg::rsp_type rsp_data
);
   import kti_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> $stable(req_data))
      else $error("stalled request changed");

   a_err_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_OK |-> rsp_data.last && rsp_data.out_value == '0)
      else $error("error response not single");

   a_last_ch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last && rsp_data.out_channel != '0
      |-> rsp_data.out_channel == CH_LAST)
      else $error("final channel mismatch");

   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");
endmodule

bind keyframe_track_interpolator kti_checker u_kti_checker (
   .clock(clock), .reset(reset),
   .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
);
`default_nettype wire
